@@ rtl/sso_pkg.sv @@
`default_nettype none
package sso_pkg;

  // Fixed geometry of the attribute table, tile store and line
  localparam int NumEntries  = 40;
  localparam int TableBytes  = 160;
  localparam int MaxPick     = 10;
  localparam int LineWidth   = 160;
  localparam int TileWords   = 2048;

  // Attribute flag bit positions inside the flags byte
  localparam int FlagBehind  = 7;
  localparam int FlagYFlip   = 6;
  localparam int FlagXFlip   = 5;
  localparam int FlagPal1    = 4;

  // Operation codes of an input request
  typedef enum logic [1:0] {
    FUNC_ATTR_WR  = 2'd0,
    FUNC_TILE_WR  = 2'd1,
    FUNC_START    = 2'd2,
    FUNC_PIXEL    = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic [1:0] CfgTall = 2'd0;
  localparam logic [1:0] CfgPal0 = 2'd1;
  localparam logic [1:0] CfgPal1 = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  scan_line;
    logic [7:0]  pixel_x;
    logic [1:0]  under_shade;
  } in_t;

  typedef struct packed {
    logic [1:0] shade;
    logic [3:0] objects_on_line;
  } out_t;

endpackage
`default_nettype wire

@@ rtl/sso_attr_ram.sv @@
`default_nettype none
module sso_attr_ram
  import sso_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [7:0]  wr_addr,
  input  wire logic [7:0]  wr_data,
  input  wire logic        rd_en,
  input  wire logic [5:0]  rd_idx,
  output logic      [31:0] rd_data
);

  logic [31:0]          mem [NumEntries];
  logic [TableBytes-1:0] vld;
  logic [31:0]          rd_q;
  logic [3:0]           rd_vld;

  // byte-wide write into the entry word; registered read of the entry and its byte valid bits
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[7:2]][8*wr_addr[1:0] +: 8] <= wr_data;
    end
    if (rd_en) begin
      rd_q   <= mem[rd_idx];
      rd_vld <= vld[{rd_idx, 2'b00} +: 4];
    end
  end

  // valid bit per byte; an unwritten byte reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      rd_data[8*b +: 8] = rd_vld[b] ? rd_q[8*b +: 8] : 8'h00;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sso_tile_ram.sv @@
`default_nettype none
module sso_tile_ram
  import sso_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [11:0] wr_addr,
  input  wire logic [7:0]  wr_data,
  input  wire logic        rd_en,
  input  wire logic [10:0] rd_addr,
  output logic      [15:0] rd_data,
  output logic             busy
);

  logic [15:0] mem [TileWords];
  logic [11:0] clr_cnt;

  assign busy = ~clr_cnt[11];

  // clearing pass after reset, one word a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 12'd1;
    end
  end

  // even byte in the low half, odd byte in the high half
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt[10:0]] <= 16'h0000;
    end else if (wr_en) begin
      mem[wr_addr[11:1]][8*wr_addr[0] +: 8] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/sprite_scanline_overlay.sv @@
`default_nettype none
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_data (in_t)
// out     | output    | out_valid / out_ready| out_data (out_t)
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Start line reads one attribute entry per cycle from the attribute RAM,
// with sorted insertion in flops. A pixel passes one picked sprite per cycle
// through the attribute read and the tile read; a column past the line goes
// straight to the final step. After reset the tile RAM is cleared with
// in_ready low. A result waiting on out_ready holds the block in its final
// step; cfg_ready is always high.
module sprite_scanline_overlay
  import sso_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_t        in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_t            out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PIX, S_DONE} state_t;

  state_t      state;
  logic        tall;
  logic [7:0]  pal0, pal1;
  logic [7:0]  line_q, px_q;
  logic [1:0]  shade_acc;
  logic [5:0]  pick_idx [MaxPick];
  logic [7:0]  pick_x   [MaxPick];
  logic [3:0]  pick_cnt;
  logic [5:0]  iss;
  logic        p1_vld;
  logic        p2_vld, p2_pal1, p2_behind;
  logic [2:0]  p2_bit;

  logic        accept, clr_busy;
  logic        attr_wr, tile_wr, attr_rd;
  logic [5:0]  attr_idx;
  logic [31:0] attr_word;
  logic [15:0] tile_word;
  logic [3:0]  height;

  assign height    = tall ? 4'd15 : 4'd7;
  assign in_ready  = (state == S_IDLE) && !clr_busy;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign attr_wr   = accept && (in_data.func == FUNC_ATTR_WR) && (in_data.addr < 12'(TableBytes));
  assign tile_wr   = accept && (in_data.func == FUNC_TILE_WR);

  // attribute read issue: whole table on scan until the pick list is full, picked list on pixel
  always_comb begin
    attr_rd  = 1'b0;
    attr_idx = iss;
    if (state == S_SCAN) begin
      attr_rd = (iss < 6'(NumEntries)) && (pick_cnt < 4'(MaxPick));
    end else if (state == S_PIX) begin
      attr_rd  = iss < {2'b00, pick_cnt};
      attr_idx = pick_idx[iss[3:0]];
    end
  end

  sso_attr_ram u_attr (
    .clk, .rst,
    .wr_en(attr_wr), .wr_addr(in_data.addr[7:0]), .wr_data(in_data.wdata),
    .rd_en(attr_rd), .rd_idx(attr_idx), .rd_data(attr_word)
  );

  // fields of the returned entry
  logic [7:0]  a_y, a_x, a_tile, a_flags;
  assign a_y     = attr_word[7:0];
  assign a_x     = attr_word[15:8];
  assign a_tile  = attr_word[23:16];
  assign a_flags = attr_word[31:24];

  // scan: line covered by the sprite span
  logic signed [9:0] top, ly;
  logic              scan_hit;
  logic [3:0]        ins;
  assign top      = $signed({2'b00, a_y}) - 10'sd16;
  assign ly       = $signed({2'b00, line_q});
  assign scan_hit = (ly >= top) && (ly <= top + $signed({6'b0, height}));

  // stable insertion point: after every kept entry with X not above the new X
  always_comb begin
    ins = '0;
    for (int i = 0; i < MaxPick; i++) begin
      if ((4'(i) < pick_cnt) && (pick_x[i] <= a_x)) ins = ins + 4'd1;
    end
  end

  // pixel stage 1: column test and tile word address
  logic [9:0]  col;
  logic        col_hit;
  logic [7:0]  row8, rowf;
  logic [3:0]  row4;
  logic [7:0]  tile_m;
  logic [10:0] tile_addr;
  logic [2:0]  bit_sel;
  assign col       = {2'b00, px_q} + 10'd8 - {2'b00, a_x};
  assign col_hit   = (col[9:3] == 7'd0);
  assign row8      = line_q - a_y + 8'd16;
  assign rowf      = a_flags[FlagYFlip] ? ({4'b0, height} - row8) : row8;
  assign row4      = rowf[3:0] & height;
  assign tile_m    = tall ? {a_tile[7:1], 1'b0} : a_tile;
  assign tile_addr = {tile_m, 3'b000} + {7'b0, row4};
  assign bit_sel   = a_flags[FlagXFlip] ? col[2:0] : (3'd7 - col[2:0]);

  sso_tile_ram u_tile (
    .clk, .rst,
    .wr_en(tile_wr), .wr_addr(in_data.addr), .wr_data(in_data.wdata),
    .rd_en(p1_vld && (state == S_PIX)), .rd_addr(tile_addr), .rd_data(tile_word),
    .busy(clr_busy)
  );

  // pixel stage 2: colour index through the palette
  logic [1:0] ci, s;
  logic [7:0] pal;
  logic       draw;
  assign ci   = {tile_word[8 + p2_bit], tile_word[p2_bit]};
  assign pal  = p2_pal1 ? pal1 : pal0;
  assign s    = 2'(pal >> {ci, 1'b0});
  assign draw = p2_vld && !(p2_behind && (s == 2'd0));

  // control, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tall      <= 1'b0;
      pal0      <= '0;
      pal1      <= '0;
      line_q    <= '0;
      pick_cnt  <= '0;
      iss       <= '0;
      p1_vld    <= 1'b0;
      p2_vld    <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < MaxPick; i++) begin
        pick_idx[i] <= '0;
        pick_x[i]   <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CfgTall: tall <= cfg_data[0];
          CfgPal0: pal0 <= cfg_data;
          CfgPal1: pal1 <= cfg_data;
          default: ;
        endcase
      end
      // taken result cleared unless the final step reloads it
      if (out_valid && out_ready && (state != S_DONE)) out_valid <= 1'b0;

      p1_vld <= attr_rd;
      if (attr_rd) iss <= iss + 6'd1;
      p2_vld    <= (state == S_PIX) && p1_vld && col_hit;
      p2_bit    <= bit_sel;
      p2_pal1   <= a_flags[FlagPal1];
      p2_behind <= a_flags[FlagBehind];

      case (state)
        S_IDLE: begin
          if (accept && (in_data.func == FUNC_START)) begin
            line_q    <= in_data.scan_line;
            pick_cnt  <= '0;
            iss       <= '0;
            shade_acc <= '0;
            state     <= S_SCAN;
          end else if (accept && (in_data.func == FUNC_PIXEL)) begin
            px_q      <= in_data.pixel_x;
            shade_acc <= in_data.under_shade;
            iss       <= '0;
            state     <= (in_data.pixel_x < 8'(LineWidth)) ? S_PIX : S_DONE;
          end
        end
        S_SCAN: begin
          if (p1_vld && scan_hit && (pick_cnt < 4'(MaxPick))) begin
            for (int i = 0; i < MaxPick; i++) begin
              if (4'(i) == ins) begin
                pick_idx[i] <= iss - 6'd1;
                pick_x[i]   <= a_x;
              end else if (4'(i) > ins) begin
                pick_idx[i] <= pick_idx[(i > 0) ? i - 1 : 0];
                pick_x[i]   <= pick_x[(i > 0) ? i - 1 : 0];
              end
            end
            pick_cnt <= pick_cnt + 4'd1;
          end
          if (!attr_rd && !p1_vld) state <= S_DONE;
        end
        S_PIX: begin
          if (draw) shade_acc <= s;
          if (!attr_rd && !p1_vld && !p2_vld) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid                <= 1'b1;
            out_data.shade           <= shade_acc;
            out_data.objects_on_line <= pick_cnt;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
